[design/mvf_pkg.sv]
// mvf_pkg: shared types and constants of the mother vertex finder
// no dependencies; used by mvf_cell and mother_vertex_finder
package mvf_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  localparam int unsigned VertexW     = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned MaxResults  = 16;
  localparam logic [CountW-1:0] VertexCountReset = 5'd16;

  // control shared by every cell of the row ring
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

[design/mvf_cell.sv]
// mvf_cell: one adjacency row of the ring; clears, sets an edge bit or takes its neighbor's row
// depends on mvf_pkg (cell_ctl_t)
module mvf_cell #(
  parameter int unsigned W = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mvf_pkg::cell_ctl_t      ctl_i,
  input  logic                    add_i,
  input  logic [$clog2(W)-1:0]    col_i,
  input  logic [W-1:0]            row_i,
  output logic [W-1:0]            row_o
);

  logic [W-1:0] row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctl_i.clr) begin
      row_d = '0;
    end else if (ctl_i.shift) begin
      row_d = row_i;
    end else if (add_i) begin
      row_d = row_q | (W'(1) << col_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

[design/mother_vertex_finder.sv]
// mother_vertex_finder: top level; ring of adjacency row cells and the find sequencer
// depends on mvf_pkg and mvf_cell
// clear and add leave the block idle; the next item is accepted in the following cycle.
// find: per candidate vertex one start state, up to n sweeps of the ring (one row
// passes the ring head per cycle) each closed by a check state, and one mother state per mother,
// then a finish state; the mother and finish states can wait on a stall on the result side.
// results leave through an output register; the block idles again once the last is loaded.
// reset (async, active low) clears the matrix at once and sets vertex_count to 16.
module mother_vertex_finder #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // action[1:0], edge_from[5:2], edge_to[9:6], zeros
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // vertex[3:0], found[4], zeros
  output logic        m_axis_tlast,  // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i     // vertex_count
);

  localparam int unsigned N  = MAX_VERTICES;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_NEXT   = 6'b000010,
    ST_SWEEP  = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_MOTHER = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [mvf_pkg::CountW-1:0] vcount_q;
  logic [CW-1:0]              n_q;
  logic [N-1:0]               mask_q, acc_q;
  logic [CW-1:0]              i_q;
  logic [IW-1:0]              step_q;
  logic                       changed_q;
  logic [IW-1:0]              pend_q;
  logic                       pend_valid_q;
  logic [mvf_pkg::CountW-1:0] cnt_q;

  logic                       out_valid_q;
  logic [mvf_pkg::VertexW-1:0] out_vertex_q;
  logic                       out_found_q, out_last_q;

  // input fields
  logic [1:0]                 in_action;
  logic [mvf_pkg::VertexW-1:0] in_from, in_to;
  logic                       in_fire;

  assign in_action = s_axis_tdata[1:0];
  assign in_from   = s_axis_tdata[5:2];
  assign in_to     = s_axis_tdata[9:6];
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // ring of row cells
  logic [N-1:0]         rows [N];
  mvf_pkg::cell_ctl_t   cell_ctl;
  logic                 add_hit;
  logic [IW-1:0]        from_idx, to_idx;

  assign from_idx = IW'(in_from);
  assign to_idx   = IW'(in_to);
  assign add_hit  = in_fire && (in_action == mvf_pkg::ACT_ADD) &&
                    ({3'b000, in_from} < 7'(N)) && ({3'b000, in_to} < 7'(N));

  assign cell_ctl.clr   = in_fire && (in_action == mvf_pkg::ACT_CLEAR);
  assign cell_ctl.shift = (state_q == ST_SWEEP);

  for (genvar c = 0; c < N; c++) begin : g_cell
    mvf_cell #(.W(N)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .add_i  (add_hit && (from_idx == IW'(c))),
      .col_i  (to_idx),
      .row_i  (rows[(c + 1) % N]),
      .row_o  (rows[c])
    );
  end

  // sweep datapath: row number step_q sits at the ring head
  logic [N-1:0] acc_sweep;
  logic         use_row, step_last, out_free, out_load;
  logic [CW-1:0] n_sat;
  logic [mvf_pkg::CountW-1:0] cnt_inc;

  assign use_row   = acc_q[step_q] && mask_q[step_q];
  assign acc_sweep = use_row ? (acc_q | (rows[0] & mask_q)) : acc_q;
  assign step_last = (step_q == IW'(N - 1));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign out_load  = out_free &&
                     (((state_q == ST_MOTHER) && pend_valid_q) || (state_q == ST_FINISH));
  assign cnt_inc   = cnt_q + 1'b1;
  assign n_sat     = ({2'b00, vcount_q} > 7'(N)) ? CW'(N) : CW'(vcount_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_action == mvf_pkg::ACT_FIND)) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        state_d = (i_q < n_q) ? ST_SWEEP : ST_FINISH;
      end
      ST_SWEEP: begin
        if (step_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (acc_q == mask_q) begin
          state_d = ST_MOTHER;
        end else if (changed_q) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_MOTHER: begin
        if (!pend_valid_q || out_free) begin
          state_d = (cnt_inc == mvf_pkg::CountW'(mvf_pkg::MaxResults)) ? ST_FINISH : ST_NEXT;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      vcount_q     <= mvf_pkg::VertexCountReset;
      n_q          <= '0;
      mask_q       <= '0;
      acc_q        <= '0;
      step_q       <= '0;
      changed_q    <= 1'b0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
      i_q          <= '0;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_found_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) vcount_q <= cfg_data_i;
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_action == mvf_pkg::ACT_FIND)) begin
            n_q          <= n_sat;
            for (int k = 0; k < N; k++) mask_q[k] <= (CW'(k) < n_sat);
            i_q          <= '0;
            cnt_q        <= '0;
            pend_valid_q <= 1'b0;
          end
        end
        ST_NEXT: begin
          acc_q     <= N'(1) << i_q;
          step_q    <= '0;
          changed_q <= 1'b0;
        end
        ST_SWEEP: begin
          acc_q     <= acc_sweep;
          changed_q <= changed_q || (acc_sweep != acc_q);
          step_q    <= step_last ? '0 : step_q + 1'b1;
        end
        ST_CHECK: begin
          changed_q <= 1'b0;
          if ((acc_q != mask_q) && !changed_q) i_q <= i_q + 1'b1;
        end
        ST_MOTHER: begin
          if (!pend_valid_q || out_free) begin
            // the previous mother is not the final one
            if (pend_valid_q) begin
              out_vertex_q <= mvf_pkg::VertexW'(pend_q);
              out_found_q  <= 1'b1;
              out_last_q   <= 1'b0;
            end
            pend_q       <= IW'(i_q);
            pend_valid_q <= 1'b1;
            cnt_q        <= cnt_inc;
            i_q          <= i_q + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_vertex_q <= pend_valid_q ? mvf_pkg::VertexW'(pend_q) : '0;
            out_found_q  <= pend_valid_q;
            out_last_q   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_found_q, out_vertex_q};
  assign m_axis_tlast  = out_last_q;

  // the ring must sit aligned whenever edges can be added
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (step_q == '0))
    else $error("row ring not aligned while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && step_last |=> (state_q == ST_CHECK))
    else $error("sweep did not end after a full ring turn");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SWEEP) || (state_q == ST_CHECK)) |-> ((acc_q & ~mask_q) == '0))
    else $error("reach set holds a vertex out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mvf_pkg::CountW'(mvf_pkg::MaxResults))
    else $error("result count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MOTHER) || (state_q == ST_FINISH)) && out_valid_q && !m_axis_tready
    && pend_valid_q |=> $stable(out_vertex_q))
    else $error("waiting result overwritten");

endmodule
